[rtl/core/sm83_pkg.sv]
`timescale 1ns / 1ps

package sm83_pkg;

    // Architectural state of the core.
    typedef struct packed {
        logic [7:0]  a;
        logic [7:0]  b;
        logic [7:0]  c;
        logic [7:0]  d;
        logic [7:0]  e;
        logic [7:0]  h;
        logic [7:0]  l;
        logic [3:0]  f;
        logic [15:0] sp;
        logic [15:0] pc;
    } state_t;

    // Per-result fields that are not part of the register view.
    typedef struct packed {
        logic        mem_write;
        logic [15:0] mem_addr;
        logic [7:0]  mem_write_data;
        logic [4:0]  cycles;
        logic        last;
    } result_t;

    // Flag bit positions within the Z N H C nibble.
    localparam int FLAG_Z = 3;
    localparam int FLAG_N = 2;
    localparam int FLAG_H = 1;
    localparam int FLAG_C = 0;

    // 8-bit register operand codes.
    localparam logic [2:0] REG_B   = 3'd0;
    localparam logic [2:0] REG_C   = 3'd1;
    localparam logic [2:0] REG_D   = 3'd2;
    localparam logic [2:0] REG_E   = 3'd3;
    localparam logic [2:0] REG_H   = 3'd4;
    localparam logic [2:0] REG_L   = 3'd5;
    localparam logic [2:0] REG_MEM = 3'd6;
    localparam logic [2:0] REG_A   = 3'd7;

    // Register pair codes.
    localparam logic [1:0] PAIR_BC = 2'd0;
    localparam logic [1:0] PAIR_DE = 2'd1;
    localparam logic [1:0] PAIR_HL = 2'd2;
    localparam logic [1:0] PAIR_SP = 2'd3;

    // ALU operation codes taken from opcode bits 5..3.
    localparam logic [2:0] ALU_ADD = 3'd0;
    localparam logic [2:0] ALU_AND = 3'd4;
    localparam logic [2:0] ALU_XOR = 3'd5;
    localparam logic [2:0] ALU_OR  = 3'd6;
    localparam logic [2:0] ALU_CP  = 3'd7;

    // Opcode patterns and masks.
    localparam logic [7:0] OP_INC8_MASK  = 8'hC7;
    localparam logic [7:0] OP_INC8       = 8'h04;
    localparam logic [7:0] OP_PAIR_MASK  = 8'hCF;
    localparam logic [7:0] OP_INC16      = 8'h03;
    localparam logic [7:0] OP_ADD_HL     = 8'h09;
    localparam logic [7:0] OP_ADD_R_MASK = 8'hF8;
    localparam logic [7:0] OP_ADD_R      = 8'h80;
    localparam logic [7:0] OP_LOGIC_MASK = 8'hE0;
    localparam logic [7:0] OP_LOGIC_R    = 8'hA0;
    localparam logic [7:0] OP_ADD_D8     = 8'hC6;
    localparam logic [7:0] OP_AND_D8     = 8'hE6;
    localparam logic [7:0] OP_XOR_D8     = 8'hEE;
    localparam logic [7:0] OP_OR_D8      = 8'hF6;
    localparam logic [7:0] OP_CP_D8      = 8'hFE;
    localparam logic [7:0] OP_ADD_SP     = 8'hE8;
    localparam logic [7:0] OP_JP         = 8'hC3;
    localparam logic [7:0] OP_JP_CC_MASK = 8'hE7;
    localparam logic [7:0] OP_JP_CC      = 8'hC2;
    localparam logic [7:0] OP_JP_HL      = 8'hE9;
    localparam logic [7:0] OP_RST_MASK   = 8'hC7;
    localparam logic [7:0] OP_RST        = 8'hC7;

    // Clock counts; zero marks an unsupported opcode.
    localparam logic [4:0] CYC_NONE = 5'd0;
    localparam logic [4:0] CYC_4    = 5'd4;
    localparam logic [4:0] CYC_8    = 5'd8;
    localparam logic [4:0] CYC_12   = 5'd12;
    localparam logic [4:0] CYC_16   = 5'd16;

endpackage

[rtl/core/sm83_exec.sv]
`timescale 1ns / 1ps

module sm83_exec
    import sm83_pkg::*;
(
    input  state_t      st_i,
    input  logic [7:0]  operation,
    input  logic [15:0] immediate,
    input  logic [7:0]  hl_mem_byte,
    output state_t      st_next,
    output result_t     res0,
    output result_t     res1,
    output logic        two_results
);

    function automatic logic [7:0] read_reg(state_t st, logic [2:0] idx);
        logic [7:0] v;
        case (idx)
            REG_B:   v = st.b;
            REG_C:   v = st.c;
            REG_D:   v = st.d;
            REG_E:   v = st.e;
            REG_H:   v = st.h;
            REG_L:   v = st.l;
            default: v = st.a;
        endcase
        return v;
    endfunction

    function automatic logic [15:0] read_pair(state_t st, logic [1:0] p);
        logic [15:0] v;
        case (p)
            PAIR_BC: v = {st.b, st.c};
            PAIR_DE: v = {st.d, st.e};
            PAIR_HL: v = {st.h, st.l};
            default: v = st.sp;
        endcase
        return v;
    endfunction

    // Returns {new A, new flags}.
    function automatic logic [11:0] alu8(logic [2:0] kind, logic [7:0] a, logic [7:0] v);
        logic [8:0] sum;
        logic [4:0] hsum;
        logic [7:0] r;
        logic [3:0] f;
        sum  = {1'b0, a} + {1'b0, v};
        hsum = {1'b0, a[3:0]} + {1'b0, v[3:0]};
        case (kind)
            ALU_ADD: begin
                r = sum[7:0];
                f = {r == 8'd0, 1'b0, hsum[4], sum[8]};
            end
            ALU_AND: begin
                r = a & v;
                f = {r == 8'd0, 1'b0, 1'b1, 1'b0};
            end
            ALU_XOR: begin
                r = a ^ v;
                f = {r == 8'd0, 3'b000};
            end
            ALU_OR: begin
                r = a | v;
                f = {r == 8'd0, 3'b000};
            end
            default: begin
                // Compare leaves A alone and flags a subtraction.
                r = a;
                f = {a == v, 1'b1, a[3:0] < v[3:0], a < v};
            end
        endcase
        return {r, f};
    endfunction

    logic [2:0]  idx_dst;
    logic [2:0]  idx_src;
    logic [1:0]  pair_sel;
    logic [15:0] hl;
    logic [7:0]  d8;

    logic        is_inc8;
    logic        is_inc16;
    logic        is_add_hl;
    logic        is_alu_r;
    logic        is_alu_i;
    logic        is_jp_cc;

    logic [7:0]  inc_old;
    logic [7:0]  inc_new;
    logic [15:0] pair_val;
    logic [15:0] pair_inc;
    logic [16:0] hl_sum;
    logic [12:0] hl_hsum;
    logic [7:0]  alu_v;
    logic [11:0] alu_res;
    logic [15:0] sp_sum;
    logic [4:0]  sp_hsum;
    logic [8:0]  sp_csum;
    logic        cc_bit;
    logic [15:0] ret_addr;

    logic [1:0]  len;
    logic        advance;

    assign idx_dst  = operation[5:3];
    assign idx_src  = operation[2:0];
    assign pair_sel = operation[5:4];
    assign hl       = {st_i.h, st_i.l};
    assign d8       = immediate[7:0];

    assign is_inc8   = (operation & OP_INC8_MASK) == OP_INC8;
    assign is_inc16  = (operation & OP_PAIR_MASK) == OP_INC16;
    assign is_add_hl = (operation & OP_PAIR_MASK) == OP_ADD_HL;
    assign is_alu_r  = ((operation & OP_ADD_R_MASK) == OP_ADD_R)
                    || ((operation & OP_LOGIC_MASK) == OP_LOGIC_R);
    assign is_alu_i  = (operation == OP_ADD_D8) || (operation == OP_AND_D8)
                    || (operation == OP_XOR_D8) || (operation == OP_OR_D8)
                    || (operation == OP_CP_D8);
    assign is_jp_cc  = (operation & OP_JP_CC_MASK) == OP_JP_CC;

    assign inc_old  = (idx_dst == REG_MEM) ? hl_mem_byte : read_reg(st_i, idx_dst);
    assign inc_new  = inc_old + 8'd1;
    assign pair_val = read_pair(st_i, pair_sel);
    assign pair_inc = pair_val + 16'd1;
    assign hl_sum   = {1'b0, pair_val} + {1'b0, hl};
    assign hl_hsum  = {1'b0, pair_val[11:0]} + {1'b0, hl[11:0]};

    assign alu_v   = is_alu_i ? d8
                   : ((idx_src == REG_MEM) ? hl_mem_byte : read_reg(st_i, idx_src));
    assign alu_res = alu8(operation[5:3], st_i.a, alu_v);

    assign sp_sum  = st_i.sp + {{8{d8[7]}}, d8};
    assign sp_hsum = {1'b0, st_i.sp[3:0]} + {1'b0, d8[3:0]};
    assign sp_csum = {1'b0, st_i.sp[7:0]} + {1'b0, d8};

    assign cc_bit   = operation[4] ? st_i.f[FLAG_C] : st_i.f[FLAG_Z];
    assign ret_addr = st_i.pc + 16'd1;

    always_comb begin
        st_next     = st_i;
        res0        = '0;
        res0.last   = 1'b1;
        res1        = '0;
        res1.last   = 1'b1;
        two_results = 1'b0;
        len         = 2'd1;
        advance     = 1'b1;

        if (is_inc8) begin
            st_next.f = {inc_new == 8'd0, 1'b0, inc_old[3:0] == 4'hF, st_i.f[FLAG_C]};
            if (idx_dst == REG_MEM) begin
                res0.mem_write      = 1'b1;
                res0.mem_addr       = hl;
                res0.mem_write_data = inc_new;
                res0.cycles         = CYC_12;
            end else begin
                res0.cycles = CYC_4;
                case (idx_dst)
                    REG_B:   st_next.b = inc_new;
                    REG_C:   st_next.c = inc_new;
                    REG_D:   st_next.d = inc_new;
                    REG_E:   st_next.e = inc_new;
                    REG_H:   st_next.h = inc_new;
                    REG_L:   st_next.l = inc_new;
                    default: st_next.a = inc_new;
                endcase
            end
        end else if (is_inc16) begin
            res0.cycles = CYC_8;
            case (pair_sel)
                PAIR_BC: {st_next.b, st_next.c} = pair_inc;
                PAIR_DE: {st_next.d, st_next.e} = pair_inc;
                PAIR_HL: {st_next.h, st_next.l} = pair_inc;
                default: st_next.sp = pair_inc;
            endcase
        end else if (is_add_hl) begin
            res0.cycles              = CYC_8;
            st_next.f                = {st_i.f[FLAG_Z], 1'b0, hl_hsum[12], hl_sum[16]};
            {st_next.h, st_next.l}   = hl_sum[15:0];
        end else if (is_alu_r || is_alu_i) begin
            st_next.a = alu_res[11:4];
            st_next.f = alu_res[3:0];
            if (is_alu_i) begin
                res0.cycles = CYC_8;
                len         = 2'd2;
            end else begin
                res0.cycles = (idx_src == REG_MEM) ? CYC_8 : CYC_4;
            end
        end else if (operation == OP_ADD_SP) begin
            res0.cycles = CYC_16;
            len         = 2'd2;
            st_next.f   = {2'b00, sp_hsum[4], sp_csum[8]};
            st_next.sp  = sp_sum;
        end else if (operation == OP_JP) begin
            res0.cycles = CYC_16;
            advance     = 1'b0;
            st_next.pc  = immediate;
        end else if (is_jp_cc) begin
            len = 2'd3;
            if (cc_bit == operation[3]) begin
                res0.cycles = CYC_16;
                advance     = 1'b0;
                st_next.pc  = immediate;
            end else begin
                res0.cycles = CYC_12;
            end
        end else if (operation == OP_JP_HL) begin
            res0.cycles = CYC_4;
            advance     = 1'b0;
            st_next.pc  = hl;
        end else if ((operation & OP_RST_MASK) == OP_RST) begin
            // High byte of the return address goes first, one below SP.
            two_results         = 1'b1;
            advance             = 1'b0;
            res0.mem_write      = 1'b1;
            res0.mem_addr       = st_i.sp - 16'd1;
            res0.mem_write_data = ret_addr[15:8];
            res0.cycles         = CYC_16;
            res0.last           = 1'b0;
            res1.mem_write      = 1'b1;
            res1.mem_addr       = st_i.sp - 16'd2;
            res1.mem_write_data = ret_addr[7:0];
            res1.cycles         = CYC_16;
            st_next.sp          = st_i.sp - 16'd2;
            st_next.pc          = {10'd0, operation[5:3], 3'b000};
        end else begin
            // Unsupported opcode: state is left untouched.
            advance = 1'b0;
        end

        if (advance) begin
            st_next.pc = st_i.pc + {14'd0, len};
        end
    end

endmodule

[rtl/core/sm83_alu_jump_execute.sv]
`timescale 1ns / 1ps

// Executes one SM83 instruction per input request: 8/16-bit INC, ADD, AND,
// XOR, OR, CP, JP in its plain, conditional and HL forms, and RST.
// The input channel (s_*) carries the opcode, its immediate and the byte at
// address HL. The result channel (m_*) carries any memory write, the clock
// count of the instruction and the register view after it.
// An instruction is decoded and executed in the cycle it is accepted; its
// result is registered and appears on m_* in the next cycle. A new request
// is accepted every cycle while results are taken and no second push write
// is pending, so the rate is one instruction per cycle. RST produces two
// results (the two stack push writes) and holds off the input while its
// second write waits in the single pending-write register set.
// When m_ready is low, the result is held and s_ready drops until it is
// taken, so the register view on m_* always belongs to the shown result.
// Reset (aresetn low, synchronous) clears all registers, flags, SP and PC
// to zero and empties the result stage.

module sm83_alu_jump_execute
    import sm83_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_operation,
    input  logic [15:0] s_immediate,
    input  logic [7:0]  s_hl_mem_byte,

    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_mem_write,
    output logic [15:0] m_mem_addr,
    output logic [7:0]  m_mem_write_data,
    output logic [4:0]  m_cycles,
    output logic [7:0]  m_out_a,
    output logic [3:0]  m_out_flags,
    output logic [15:0] m_out_bc,
    output logic [15:0] m_out_de,
    output logic [15:0] m_out_hl,
    output logic [15:0] m_out_sp,
    output logic [15:0] m_out_pc,
    output logic        m_last
);

    state_t  st_reg;
    state_t  st_next;
    result_t res0;
    result_t res1;
    logic    two_results;

    logic    m_valid_reg;
    result_t res_reg;
    logic    pend_valid_reg;
    result_t pend_reg;
    logic    accept;

    sm83_exec u_exec (
        .st_i        (st_reg),
        .operation   (s_operation),
        .immediate   (s_immediate),
        .hl_mem_byte (s_hl_mem_byte),
        .st_next     (st_next),
        .res0        (res0),
        .res1        (res1),
        .two_results (two_results)
    );

    assign s_ready = !pend_valid_reg && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg         <= '0;
            m_valid_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else if (accept) begin
            st_reg         <= st_next;
            m_valid_reg    <= 1'b1;
            pend_valid_reg <= two_results;
        end else if (m_valid_reg && m_ready) begin
            // The pending second push write, if any, moves up.
            m_valid_reg    <= pend_valid_reg;
            pend_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            res_reg  <= res0;
            pend_reg <= res1;
        end else if (m_valid_reg && m_ready && pend_valid_reg) begin
            res_reg  <= pend_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_mem_write      = res_reg.mem_write;
    assign m_mem_addr       = res_reg.mem_addr;
    assign m_mem_write_data = res_reg.mem_write_data;
    assign m_cycles         = res_reg.cycles;
    assign m_last           = res_reg.last;
    assign m_out_a          = st_reg.a;
    assign m_out_flags      = st_reg.f;
    assign m_out_bc         = {st_reg.b, st_reg.c};
    assign m_out_de         = {st_reg.d, st_reg.e};
    assign m_out_hl         = {st_reg.h, st_reg.l};
    assign m_out_sp         = st_reg.sp;
    assign m_out_pc         = st_reg.pc;

endmodule

[rtl/core/sm83_chk.sv]
`timescale 1ns / 1ps

module sm83_chk
    import sm83_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_mem_write,
    input logic [15:0] m_mem_addr,
    input logic [4:0]  m_cycles,
    input logic        m_last
);

    // A stalled result keeps its write address and clock count.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_mem_addr) && $stable(m_cycles))
        else $error("stalled result changed");

    // The first RST push is followed at once by the second, one byte lower.
    a_rst_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last |=>
            m_valid && m_last && m_mem_write && m_cycles == CYC_16
            && m_mem_addr == $past(m_mem_addr) - 16'd1)
        else $error("second push write missing or misplaced");

    // No new request is taken while a push pair is still being delivered.
    a_no_accept_mid_rst: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last |-> !s_ready)
        else $error("input accepted during a push pair");

    // An unsupported opcode writes nothing and ends at once.
    a_unsupported: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_cycles == CYC_NONE |-> !m_mem_write && m_last)
        else $error("unsupported opcode produced a write");

endmodule

bind sm83_alu_jump_execute sm83_chk u_sm83_chk (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_mem_write (m_mem_write),
    .m_mem_addr  (m_mem_addr),
    .m_cycles    (m_cycles),
    .m_last      (m_last)
);
